// ===== rtl/core/qpsdm_pkg.sv =====
// shared types, constants and constellation functions for the soft demapper
package qpsdm_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_POINTS   = 64;
    localparam int DEF_SAMPLE_WIDTH = 16;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_SCHEME  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 4'd1;

    localparam int SCHEME_W = 3;
    localparam int NOISE_W  = 16;
    localparam logic [SCHEME_W-1:0] SCH_BPSK  = 3'd0;
    localparam logic [SCHEME_W-1:0] SCH_QPSK  = 3'd1;
    localparam logic [SCHEME_W-1:0] SCH_8PSK  = 3'd2;
    localparam logic [SCHEME_W-1:0] SCH_16QAM = 3'd3;
    localparam logic [SCHEME_W-1:0] SCH_64QAM = 3'd4;
    localparam logic [SCHEME_W-1:0] SCHEME_RST = SCH_BPSK;
    localparam logic [NOISE_W-1:0]  NOISE_RST  = 16'd256;

    // constellation points, Q2.12
    localparam int PT_W     = 14;
    localparam int PT_IDX_W = 6;   // up to 64 points
    localparam int CNT_W    = 7;   // holds a point count of 64
    localparam int NUM_LANES = 6;  // one per bit position
    localparam int LANE_W   = 3;
    localparam int BPS_W    = 3;

    // distances and llr scaling
    localparam int DIST_W    = 51;
    localparam logic [DIST_W-1:0] FAR_DIST = {1'b1, {(DIST_W-1){1'b0}}};
    localparam int DIFF_W    = DIST_W + 1;
    localparam int MAG_LO_W  = 26;
    localparam int MAG_HI_W  = DIST_W - MAG_LO_W;
    localparam int PL_W      = MAG_LO_W + NOISE_W;
    localparam int PH_W      = MAG_HI_W + NOISE_W;
    localparam int PROD_W    = 64;
    localparam int LLR_SHIFT = 24;
    localparam int R_W       = PROD_W - LLR_SHIFT;
    localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'(1) << (LLR_SHIFT - 1);
    localparam int LLR_W     = 16;
    localparam logic [R_W-1:0] R_POS_LIM = R_W'(32767);
    localparam logic [R_W-1:0] R_NEG_LIM = R_W'(32768);
    localparam logic [LLR_W-1:0] LLR_MAX = 16'h7fff;
    localparam logic [LLR_W-1:0] LLR_MIN = 16'h8000;

    localparam int OUT_TDATA_W = 24;

    // controller to datapath commands
    typedef struct packed {
        logic                start;    // capture symbol, reset minima
        logic                issue;    // push a point into the distance pipe
        logic [PT_IDX_W-1:0] idx;
        logic                ld_diff;
        logic                ld_mul;
        logic                ld_sum;
        logic                ld_out;
        logic [LANE_W-1:0]   sh;       // bit position of the current word
        logic                last;
    } ctl_cmd_t;

    function automatic logic [BPS_W-1:0] bits_for(input logic [SCHEME_W-1:0] s);
        logic [BPS_W-1:0] b;
        unique case (s)
            SCH_QPSK:  b = 3'd2;
            SCH_8PSK:  b = 3'd3;
            SCH_16QAM: b = 3'd4;
            SCH_64QAM: b = 3'd6;
            default:   b = 3'd1;
        endcase
        return b;
    endfunction

    function automatic logic signed [PT_W-1:0] qam16_lvl(input logic [1:0] k);
        logic signed [PT_W-1:0] v;
        unique case (k)
            2'd0: v = -14'sd3886;
            2'd1: v = -14'sd1295;
            2'd2: v =  14'sd3886;
            2'd3: v =  14'sd1295;
        endcase
        return v;
    endfunction

    function automatic logic signed [PT_W-1:0] qam64_lvl(input logic [2:0] k);
        logic signed [PT_W-1:0] v;
        unique case (k)
            3'd0: v = -14'sd4424;
            3'd1: v = -14'sd3160;
            3'd2: v = -14'sd632;
            3'd3: v = -14'sd1896;
            3'd4: v =  14'sd3160;
            3'd5: v =  14'sd4424;
            3'd6: v =  14'sd1896;
            3'd7: v =  14'sd632;
        endcase
        return v;
    endfunction

    function automatic logic signed [PT_W-1:0] psk8_x(input logic [2:0] k);
        logic signed [PT_W-1:0] v;
        unique case (k)
            3'd0: v =  14'sd4096;
            3'd1: v =  14'sd2896;
            3'd2: v = -14'sd2896;
            3'd3: v =  14'sd0;
            3'd4: v =  14'sd0;
            3'd5: v =  14'sd2896;
            3'd6: v = -14'sd2896;
            3'd7: v = -14'sd4096;
        endcase
        return v;
    endfunction

    function automatic logic signed [PT_W-1:0] psk8_y(input logic [2:0] k);
        logic signed [PT_W-1:0] v;
        unique case (k)
            3'd0: v =  14'sd0;
            3'd1: v =  14'sd2896;
            3'd2: v =  14'sd2896;
            3'd3: v =  14'sd4096;
            3'd4: v = -14'sd4096;
            3'd5: v = -14'sd2896;
            3'd6: v = -14'sd2896;
            3'd7: v =  14'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [PT_W-1:0] point_x(input logic [SCHEME_W-1:0] s,
                                                       input logic [PT_IDX_W-1:0] k);
        logic signed [PT_W-1:0] v;
        unique case (s)
            SCH_QPSK:  v = k[0] ? -14'sd2896 : 14'sd2896;
            SCH_8PSK:  v = psk8_x(k[2:0]);
            SCH_16QAM: v = qam16_lvl(k[1:0]);
            SCH_64QAM: v = qam64_lvl(k[2:0]);
            default:   v = k[0] ? 14'sd4096 : -14'sd4096;
        endcase
        return v;
    endfunction

    function automatic logic signed [PT_W-1:0] point_y(input logic [SCHEME_W-1:0] s,
                                                       input logic [PT_IDX_W-1:0] k);
        logic signed [PT_W-1:0] v;
        unique case (s)
            SCH_QPSK:  v = k[1] ? -14'sd2896 : 14'sd2896;
            SCH_8PSK:  v = psk8_y(k[2:0]);
            SCH_16QAM: v = -qam16_lvl(k[3:2]);
            SCH_64QAM: v = -qam64_lvl(k[5:3]);
            default:   v = 14'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/qpsdm_ctrl.sv =====
// sequencer for the soft demapper: point scan, then one llr word per bit
module qpsdm_ctrl #(
    parameter int MAX_POINTS = qpsdm_pkg::DEF_MAX_POINTS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [qpsdm_pkg::SCHEME_W-1:0]    scheme,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              out_free,
    output qpsdm_pkg::ctl_cmd_t               cmd
);
    import qpsdm_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_DRAIN2 = 3'd3;
    localparam logic [2:0] ST_DIFF   = 3'd4;
    localparam logic [2:0] ST_MUL    = 3'd5;
    localparam logic [2:0] ST_SUM    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] npts_reg, npts_next;
    logic [BPS_W-1:0] bps_reg, bps_next;
    logic [BPS_W-1:0] bit_reg, bit_next;
    logic [BPS_W-1:0] bps_in;
    logic [CNT_W-1:0] pts_in;
    logic             last_bit;

    assign bps_in   = bits_for(scheme);
    assign pts_in   = CNT_W'(1) << bps_in;
    assign last_bit = (bit_reg == bps_reg - BPS_W'(1));
    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        npts_next  = npts_reg;
        bps_next   = bps_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg[PT_IDX_W-1:0];
        cmd.sh     = LANE_W'(bps_reg - BPS_W'(1) - bit_reg);
        cmd.last   = last_bit;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    cnt_next   = '0;
                    bit_next   = '0;
                    bps_next   = bps_in;
                    // scan is capped at the configured point count
                    npts_next  = (pts_in > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pts_in;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == npts_reg - CNT_W'(1)) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1: begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.ld_diff = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                cmd.ld_mul = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.ld_sum = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.ld_out = 1'b1;
                    bit_next   = bit_reg + BPS_W'(1);
                    state_next = last_bit ? ST_IDLE : ST_DIFF;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            npts_reg  <= '0;
            bps_reg   <= '0;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            npts_reg  <= npts_next;
            bps_reg   <= bps_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

// ===== rtl/core/qpsdm_dp.sv =====
// datapath: distance pipe, per-bit minima, llr scaling and output register
module qpsdm_dp #(
    parameter int SAMPLE_WIDTH = qpsdm_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [qpsdm_pkg::SCHEME_W-1:0]       scheme,
    input  logic [qpsdm_pkg::NOISE_W-1:0]        noise_scale,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_i,
    input  logic signed [SAMPLE_WIDTH-1:0]       in_q,
    input  logic                                 in_blk,
    input  qpsdm_pkg::ctl_cmd_t                  cmd,
    output logic                                 out_free,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic                                 out_hard,
    output logic [qpsdm_pkg::LLR_W-1:0]          out_llr,
    output logic                                 out_last,
    output logic                                 out_blk
);
    import qpsdm_pkg::*;

    localparam int DXW  = ((SAMPLE_WIDTH > PT_W) ? SAMPLE_WIDTH : PT_W) + 1;
    localparam int SQ_W = 2 * DXW;

    // symbol
    logic signed [SAMPLE_WIDTH-1:0] ri_reg, rq_reg;
    logic                           blk_reg;

    // distance pipe
    logic signed [PT_W-1:0]      px, py;
    logic signed [DXW-1:0]       dx_reg, dx_next, dy_reg, dy_next;
    logic [PT_IDX_W-1:0]         a_idx_reg, b_idx_reg;
    logic                        a_vld_reg, b_vld_reg;
    logic signed [SQ_W-1:0]      sqx_reg, sqx_next, sqy_reg, sqy_next;
    logic [DIST_W-1:0]           pt_dist;

    // minima
    logic [DIST_W-1:0]   d0_reg [NUM_LANES];
    logic [DIST_W-1:0]   d1_reg [NUM_LANES];
    logic [DIST_W-1:0]   d0_next [NUM_LANES];
    logic [DIST_W-1:0]   d1_next [NUM_LANES];
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [PT_IDX_W-1:0] best_idx_reg, best_idx_next;

    // llr scaling
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [DIFF_W-1:0]        mag;
    logic                     neg_reg, hb_reg, last_reg;
    logic [PL_W-1:0]          pl_reg, pl_next;
    logic [PH_W-1:0]          ph_reg, ph_next;
    logic [PROD_W-1:0]        p_reg, p_next;
    logic [PROD_W-1:0]        rsum;
    logic [R_W-1:0]           r;
    logic [LLR_W-1:0]         llr_next;

    logic out_valid_reg, out_valid_next;
    logic out_hard_reg, out_last_reg, out_blk_reg;
    logic [LLR_W-1:0] out_llr_reg;

    // stage a: point lookup and offsets
    always_comb begin
        px      = point_x(scheme, cmd.idx);
        py      = point_y(scheme, cmd.idx);
        dx_next = DXW'(ri_reg) - DXW'(px);
        dy_next = DXW'(rq_reg) - DXW'(py);
    end

    // stage b: squares
    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;

    // stage c: distance and running minima
    assign pt_dist = {{(DIST_W-SQ_W){1'b0}}, sqx_reg} + {{(DIST_W-SQ_W){1'b0}}, sqy_reg};

    always_comb begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        for (int k = 0; k < NUM_LANES; k++) begin
            d0_next[k] = d0_reg[k];
            d1_next[k] = d1_reg[k];
        end
        if (cmd.start) begin
            best_next     = '1;
            best_idx_next = '0;
            for (int k = 0; k < NUM_LANES; k++) begin
                d0_next[k] = FAR_DIST;
                d1_next[k] = FAR_DIST;
            end
        end else if (b_vld_reg) begin
            // first point wins ties
            if (pt_dist < best_reg) begin
                best_next     = pt_dist;
                best_idx_next = b_idx_reg;
            end
            for (int k = 0; k < NUM_LANES; k++) begin
                if (b_idx_reg[k]) begin
                    if (pt_dist < d1_reg[k]) d1_next[k] = pt_dist;
                end else begin
                    if (pt_dist < d0_reg[k]) d0_next[k] = pt_dist;
                end
            end
        end
    end

    // llr: difference, split product, recombine, round and saturate
    assign diff_next = $signed({1'b0, d1_reg[cmd.sh]}) - $signed({1'b0, d0_reg[cmd.sh]});
    assign mag       = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign pl_next   = PL_W'(mag[MAG_LO_W-1:0]) * PL_W'(noise_scale);
    assign ph_next   = PH_W'(mag[DIST_W-1:MAG_LO_W]) * PH_W'(noise_scale);
    assign p_next    = PROD_W'({ph_reg, {MAG_LO_W{1'b0}}}) + PROD_W'(pl_reg);
    assign rsum      = p_reg + ROUND_ADD;
    assign r         = rsum[PROD_W-1:LLR_SHIFT];

    always_comb begin
        if (neg_reg) begin
            llr_next = (r > R_NEG_LIM) ? LLR_MIN : LLR_W'(~r[LLR_W-1:0] + LLR_W'(1));
        end else begin
            llr_next = (r > R_POS_LIM) ? LLR_MAX : r[LLR_W-1:0];
        end
    end

    // output word register
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            a_vld_reg     <= cmd.issue;
            b_vld_reg     <= a_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ri_reg  <= in_i;
            rq_reg  <= in_q;
            blk_reg <= in_blk;
        end
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        a_idx_reg    <= cmd.idx;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        b_idx_reg    <= a_idx_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        for (int k = 0; k < NUM_LANES; k++) begin
            d0_reg[k] <= d0_next[k];
            d1_reg[k] <= d1_next[k];
        end
        if (cmd.ld_diff) begin
            diff_reg <= diff_next;
            hb_reg   <= best_idx_reg[cmd.sh];
            last_reg <= cmd.last;
        end
        if (cmd.ld_mul) begin
            pl_reg  <= pl_next;
            ph_reg  <= ph_next;
            neg_reg <= diff_reg[DIFF_W-1];
        end
        if (cmd.ld_sum) begin
            p_reg <= p_next;
        end
        if (cmd.ld_out) begin
            out_hard_reg <= hb_reg;
            out_llr_reg  <= llr_next;
            out_last_reg <= last_reg;
            out_blk_reg  <= last_reg && blk_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hard  = out_hard_reg;
    assign out_llr   = out_llr_reg;
    assign out_last  = out_last_reg;
    assign out_blk   = out_blk_reg;

endmodule

// ===== rtl/core/qam_psk_soft_demapper.sv =====
// top level of the max-log soft demapper for bpsk, qpsk, 8psk, 16qam and 64qam
// per symbol: a scan over n points, then the drain states ST_DRAIN1 and ST_DRAIN2,
//   then the four-step llr unit per bit; n is 2, 4, 8, 16 or 64, capped at
//   MAX_POINTS, and output stalls hold the llr unit
// throughput: one symbol at a time; set by the single distance pipe taking one
//   point a cycle and the four-step llr unit per bit
// reset: synchronous, active low; scheme returns to bpsk and noise scale to 1.0
module qam_psk_soft_demapper #(
    parameter int MAX_POINTS   = qpsdm_pkg::DEF_MAX_POINTS,
    parameter int SAMPLE_WIDTH = qpsdm_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [qpsdm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qpsdm_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    // received symbols
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // i_sample, q_sample, zero padding
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    input  logic                                  s_tlast,   // block_end

    // soft bits
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hard_bit, llr, zero padding
    output logic [qpsdm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tlast,   // last_bit
    output logic                                  m_tuser    // block_end_out
);
    import qpsdm_pkg::*;

    // configuration registers
    logic [SCHEME_W-1:0] scheme_reg, scheme_next;
    logic [NOISE_W-1:0]  noise_reg, noise_next;

    // controller and datapath links
    ctl_cmd_t   cmd;
    logic       out_free;
    logic       in_ready;
    logic [LLR_W-1:0] llr;
    logic       hard;

    // unknown register indexes are dropped; upper data bits ignored
    always_comb begin
        scheme_next = scheme_reg;
        noise_next  = noise_reg;
        if (cfg_wr_en) begin
            if (cfg_index == REG_MOD_SCHEME) begin
                scheme_next = cfg_wdata[SCHEME_W-1:0];
            end else if (cfg_index == REG_NOISE_SCALE) begin
                noise_next = cfg_wdata[NOISE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg <= SCHEME_RST;
            noise_reg  <= NOISE_RST;
        end else begin
            scheme_reg <= scheme_next;
            noise_reg  <= noise_next;
        end
    end

    // sequencer: scan points, then walk bits msb first
    qpsdm_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .scheme   (scheme_reg),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    // distances, minima and llr arithmetic; owns the output word register
    qpsdm_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .scheme      (scheme_reg),
        .noise_scale (noise_reg),
        .in_i        (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_q        (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .in_blk      (s_tlast),
        .cmd         (cmd),
        .out_free    (out_free),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_hard    (hard),
        .out_llr     (llr),
        .out_last    (m_tlast),
        .out_blk     (m_tuser)
    );

    assign s_tready = in_ready;

    // pack the word: hard bit lowest, llr above, zeros to the byte boundary
    assign m_tdata = {{(OUT_TDATA_W-LLR_W-1){1'b0}}, llr, hard};

    // one symbol at a time: a taken symbol closes the input until its last word is loaded into the output register
    a_one_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // the block-end flag only ever rides on the final bit of a symbol
    a_blk_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("block end without last bit");

    // a new word is never loaded over one still waiting downstream
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_out |-> out_free)
        else $error("output word overwritten");

    // a symbol is only captured while the input is open, never while the scan runs
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !cmd.issue && s_tready)
        else $error("symbol captured outside idle");

endmodule

// ===== tb/qam_psk_soft_demapper_test.sv =====
// self-checking testbench for the qam/psk max-log soft demapper
module qam_psk_soft_demapper_test;
    import qpsdm_pkg::*;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int NPTS_CAP    = DEF_MAX_POINTS;
    localparam int S_TDATA_W   = ((2 * SW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;   // receiver hold-off, long enough to back up the input
    localparam int DRAIN_WAIT  = 100;   // wait for stray words; longer than the worst symbol latency without stalls
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_SYMS  = 40;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

    // constellation levels, q2.12
    localparam int LVL_AXIS = 4096;
    localparam int LVL_DIAG = 2896;
    localparam int Q16_IN   = 1295;
    localparam int Q16_OUT  = 3886;
    localparam int Q64_L1   = 632;
    localparam int Q64_L3   = 1896;
    localparam int Q64_L5   = 3160;
    localparam int Q64_L7   = 4424;

    localparam longint FAR_SQ_DIST = longint'(1) << 50;

    // one received symbol waiting to be offered
    typedef struct packed {
        logic [SW-1:0] i_val;
        logic [SW-1:0] q_val;
        logic          blk_end;
    } sym_item_t;

    // one predicted soft bit
    typedef struct packed {
        logic             hard;
        logic [LLR_W-1:0] llr;
        logic             last;
        logic             blk_end;
    } soft_bit_t;

    // clock, reset and block ports; every input that the bench drives is known from time zero
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_W-1:0]      s_tdata   = '0;   // i_sample, q_sample
    logic                      s_tlast   = 1'b0; // block_end
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_tdata;          // hard_bit, llr, zero padding
    logic                      m_tlast;          // last_bit
    logic                      m_tuser;          // block_end_out

    // testbench copy of the configuration
    logic [SCHEME_W-1:0] scheme_cfg = SCHEME_RST;
    logic [NOISE_W-1:0]  noise_cfg  = NOISE_RST;

    sym_item_t pending_syms[$];
    soft_bit_t soft_bits_due[$];

    int  mismatches   = 0;
    int  cycle_count  = 0;
    bit  no_idle      = 1'b0;  // both sides run flat out when set
    bit  sym_accepted = 1'b0;
    bit  word_taken   = 1'b0;
    int  tx_gap       = 0;
    int  rx_gap       = 0;
    int  hold_req     = 0;
    int  hold_seen    = 0;
    int  hold_left    = 0;

    always #10 aclk = ~aclk;

    qam_psk_soft_demapper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    function automatic int bits_per_symbol(input logic [SCHEME_W-1:0] s);
        case (s)
            SCH_QPSK:  return 2;
            SCH_8PSK:  return 3;
            SCH_16QAM: return 4;
            SCH_64QAM: return 6;
            default:   return 1;   // unknown codes fall back to bpsk
        endcase
    endfunction

    // amplitude levels per axis: gray order for 16qam, not for 64qam
    function automatic int gray_level_16(input int k);
        case (k & 3)
            0:       return -Q16_OUT;
            1:       return -Q16_IN;
            2:       return Q16_OUT;
            default: return Q16_IN;
        endcase
    endfunction

    function automatic int gray_level_64(input int k);
        case (k & 7)
            0:       return -Q64_L7;
            1:       return -Q64_L5;
            2:       return -Q64_L1;
            3:       return -Q64_L3;
            4:       return Q64_L5;
            5:       return Q64_L7;
            6:       return Q64_L3;
            default: return Q64_L1;
        endcase
    endfunction

    function automatic void constel_point(input logic [SCHEME_W-1:0] s, input int idx,
                                          output int px, output int py);
        case (s)
            SCH_QPSK: begin
                px = (idx & 1) ? -LVL_DIAG : LVL_DIAG;
                py = (idx & 2) ? -LVL_DIAG : LVL_DIAG;
            end
            SCH_8PSK: begin
                // one point per index around the circle; the order is not gray
                case (idx & 7)
                    0:       begin px =  LVL_AXIS; py =  0;        end
                    1:       begin px =  LVL_DIAG; py =  LVL_DIAG; end
                    2:       begin px = -LVL_DIAG; py =  LVL_DIAG; end
                    3:       begin px =  0;        py =  LVL_AXIS; end
                    4:       begin px =  0;        py = -LVL_AXIS; end
                    5:       begin px =  LVL_DIAG; py = -LVL_DIAG; end
                    6:       begin px = -LVL_DIAG; py = -LVL_DIAG; end
                    default: begin px = -LVL_AXIS; py =  0;        end
                endcase
            end
            SCH_16QAM: begin
                px = gray_level_16(idx);
                py = -gray_level_16(idx >> 2);
            end
            SCH_64QAM: begin
                px = gray_level_64(idx);
                py = -gray_level_64(idx >> 3);
            end
            default: begin
                px = (idx & 1) ? LVL_AXIS : -LVL_AXIS;
                py = 0;
            end
        endcase
    endfunction

    // distance difference times noise scale, q32.32 down to saturated q8.8
    function automatic logic [LLR_W-1:0] scaled_llr(input longint diff,
                                                    input logic [NOISE_W-1:0] ns);
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        logic [63:0] neg_r;
        if (diff < 0)
            mag = -diff;
        else
            mag = diff;
        prod = mag * {48'd0, ns};    // product wraps at 64 bits
        r = (prod + (64'd1 << 23)) >> 24;
        if (diff < 0) begin
            if (r > 64'd32768)
                r = 64'd32768;
            neg_r = -r;
            return neg_r[LLR_W-1:0];
        end
        if (r > 64'd32767)
            r = 64'd32767;
        return r[LLR_W-1:0];
    endfunction

    // work out every soft bit of one accepted symbol
    function automatic void predict_symbol(input logic [SW-1:0] i_raw,
                                           input logic [SW-1:0] q_raw,
                                           input logic blk);
        longint    ri, rq, dx, dy, best, d0, d1;
        longint    pt_dist [NPTS_CAP];
        int        nbits, npts, best_idx, px, py, sh;
        soft_bit_t sb;
        ri = $signed(i_raw);
        rq = $signed(q_raw);
        nbits = bits_per_symbol(scheme_cfg);
        npts = (1 << nbits) < NPTS_CAP ? (1 << nbits) : NPTS_CAP;
        best = 0;
        best_idx = 0;
        for (int j = 0; j < npts; j++) begin
            constel_point(scheme_cfg, j, px, py);
            dx = ri - px;
            dy = rq - py;
            pt_dist[j] = dx * dx + dy * dy;
            // strict compare so the first point keeps a tie
            if (j == 0 || pt_dist[j] < best) begin
                best = pt_dist[j];
                best_idx = j;
            end
        end
        for (int b = 0; b < nbits; b++) begin
            sh = nbits - 1 - b;
            d0 = FAR_SQ_DIST;
            d1 = FAR_SQ_DIST;
            for (int j = 0; j < npts; j++) begin
                if ((j >> sh) & 1) begin
                    if (pt_dist[j] < d1)
                        d1 = pt_dist[j];
                end else begin
                    if (pt_dist[j] < d0)
                        d0 = pt_dist[j];
                end
            end
            sb.hard    = best_idx[sh];
            sb.llr     = scaled_llr(d1 - d0, noise_cfg);
            sb.last    = (b == nbits - 1);
            sb.blk_end = (b == nbits - 1) && blk;
            soft_bits_due.push_back(sb);
        end
    endfunction

    function automatic void check_field(input string what,
                                        input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // ---------------------------------------------------------------------
    // driver: offers queued symbols, with a random gap after each one
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin : sym_driver
        sym_item_t nxt;
        // only move on once the current word has gone
        if (!s_tvalid || sym_accepted) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_syms.size() != 0) begin
                nxt = pending_syms.pop_front();
                s_tdata  <= {nxt.q_val, nxt.i_val};
                s_tlast  <= nxt.blk_end;
                s_tvalid <= 1'b1;
                tx_gap = no_idle ? 0 : $urandom_range(0, 3);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // receiver: random stall per word, plus a long hold-off on request
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin : word_receiver
        if (word_taken)
            rx_gap = no_idle ? 0 : $urandom_range(0, 3);
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // monitor: predicts on every accepted symbol, checks every soft bit
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : word_monitor
        soft_bit_t want;
        sym_accepted <= aresetn && s_tvalid && s_tready;
        word_taken   <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_symbol(s_tdata[SW-1:0], s_tdata[2*SW-1:SW], s_tlast);
            if (m_tvalid && m_tready) begin
                if (soft_bits_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none, got tdata %h",
                             $time, m_tdata);
                end else begin
                    want = soft_bits_due.pop_front();
                    check_field("hard_bit", want.hard, m_tdata[0]);
                    check_field("llr", $signed(want.llr), $signed(m_tdata[16:1]));
                    check_field("last_bit", want.last, m_tlast);
                    check_field("block_end_out", want.blk_end, m_tuser);
                end
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    // wait until the sender is empty and every soft bit has come back
    task automatic wait_idle();
        @(posedge aclk);
        while (pending_syms.size() != 0 || s_tvalid || soft_bits_due.size() != 0)
            @(posedge aclk);
    endtask

    // register write, only ever issued while idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_MOD_SCHEME)
            scheme_cfg = val[SCHEME_W-1:0];   // upper data bits dropped
        else if (idx == REG_NOISE_SCALE)
            noise_cfg = val[NOISE_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_sym(input logic [SW-1:0] i_val, input logic [SW-1:0] q_val,
                            input logic blk);
        sym_item_t it;
        it.i_val   = i_val;
        it.q_val   = q_val;
        it.blk_end = blk;
        pending_syms.push_back(it);
    endtask

    function automatic logic [SW-1:0] jitter(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SW-1:0];
    endfunction

    // mostly noisy copies of real points, some exact points, some anywhere
    task automatic add_random_syms(input int count);
        int kind, idx, px, py, npts;
        npts = 1 << bits_per_symbol(scheme_cfg);
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            idx  = $urandom_range(0, npts - 1);
            constel_point(scheme_cfg, idx, px, py);
            if (kind < 7)
                push_sym(jitter(px, 700), jitter(py, 700), $urandom_range(0, 3) == 0);
            else if (kind == 7)
                push_sym(jitter(px, 0), jitter(py, 0), $urandom_range(0, 3) == 0);
            else
                push_sym(SW'($urandom_range(0, 65535)), SW'($urandom_range(0, 65535)),
                         $urandom_range(0, 3) == 0);
        end
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial begin : test_seq
        logic [SCHEME_W-1:0] ph_scheme;
        logic [NOISE_W-1:0]  ph_noise;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: bpsk, unit noise scale; origin is a tie
        push_sym(16'h0000, 16'h0000, 1'b0);
        push_sym(16'h7fff, 16'h7fff, 1'b0);
        push_sym(16'h8000, 16'h8000, 1'b1);
        push_sym(SW'(LVL_AXIS), 16'h0000, 1'b0);
        wait_idle();

        // writes to unknown indexes must leave the block in bpsk
        write_reg(REG_SPARE_HI, 16'h0003);
        write_reg(REG_SPARE_LO, 16'hffff);
        push_sym(SW'(-LVL_AXIS), 16'h0000, 1'b1);
        wait_idle();

        write_reg(REG_MOD_SCHEME, CFG_DATA_W'(SCH_QPSK));
        push_sym(SW'(LVL_DIAG), SW'(-LVL_DIAG), 1'b0);
        push_sym(16'h0000, 16'h0000, 1'b1);
        wait_idle();

        write_reg(REG_MOD_SCHEME, CFG_DATA_W'(SCH_8PSK));
        push_sym(16'h0000, 16'h0000, 1'b0);
        push_sym(SW'(-LVL_AXIS), 16'h0000, 1'b1);
        push_sym(16'h7fff, 16'h8000, 1'b0);
        wait_idle();

        write_reg(REG_MOD_SCHEME, CFG_DATA_W'(SCH_16QAM));
        push_sym(SW'(Q16_IN), SW'(-Q16_IN), 1'b0);
        push_sym(16'h0000, 16'h0000, 1'b1);
        wait_idle();

        // upper data bits ignored: this lands on 64qam; full noise scale saturates
        write_reg(REG_MOD_SCHEME, 16'hfffc);
        write_reg(REG_NOISE_SCALE, 16'hffff);
        push_sym(16'h8000, 16'h8000, 1'b0);
        push_sym(SW'(Q64_L1), SW'(-Q64_L1), 1'b0);
        push_sym(16'h7fff, 16'h7fff, 1'b1);
        wait_idle();

        // unknown scheme codes act as bpsk; zero noise scale zeroes every llr
        write_reg(REG_MOD_SCHEME, 16'h0005);
        write_reg(REG_NOISE_SCALE, 16'h0000);
        push_sym(16'd1000, SW'(-3000), 1'b0);
        push_sym(16'hffff, 16'h0000, 1'b1);
        wait_idle();

        write_reg(REG_MOD_SCHEME, 16'h00ff);
        write_reg(REG_NOISE_SCALE, NOISE_RST);
        push_sym(16'd300, 16'h0000, 1'b1);
        wait_idle();

        // random phases, each with its own settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       ph_scheme = SCH_BPSK;
                1:       ph_scheme = SCH_QPSK;
                2:       ph_scheme = SCH_8PSK;
                3:       ph_scheme = SCH_16QAM;
                4:       ph_scheme = SCH_64QAM;
                8:       ph_scheme = SCH_64QAM;
                default: ph_scheme = SCHEME_W'($urandom_range(0, 7));
            endcase
            case (ph)
                2:       ph_noise = 16'h0000;
                4:       ph_noise = 16'hffff;
                6:       ph_noise = 16'h0001;
                7:       ph_noise = NOISE_RST;
                default: ph_noise = NOISE_W'($urandom_range(0, 65535));
            endcase
            write_reg(REG_MOD_SCHEME, CFG_DATA_W'(ph_scheme));
            write_reg(REG_NOISE_SCALE, ph_noise);
            no_idle = (ph % 3 == 1);

            if (ph == 5) begin
                // sender stops half-way until everything has drained
                add_random_syms(PHASE_SYMS / 2);
                wait_idle();
                add_random_syms(PHASE_SYMS - PHASE_SYMS / 2);
            end else begin
                add_random_syms(PHASE_SYMS);
                // receiver holds off while the sender keeps offering
                if (ph == 3)
                    hold_req++;
            end
            wait_idle();
        end

        // allow for any stray words after the last expected one
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && soft_bits_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
